FILE: rtl/least_squares_line_fit_defines.svh
// Assertion macros for the least-squares line fit block.
// Used by the port checker; needs clk and rst_n in the scope of each use.
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define LSLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define LSLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lslf_pkg.sv
// Shared widths, payload structs, product codes and back-end state type
// for the least-squares line fit. No dependencies.
package lslf_pkg;

  localparam int X_W         = 20;
  localparam int Y_W         = 24;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SX_W        = 36;
  localparam int SXX_W       = 56;
  localparam int SY_W        = 40;
  localparam int SXY_W       = 60;
  localparam int XX_W        = 2 * X_W;
  localparam int XY_W        = X_W + Y_W;
  localparam int COEF_W      = 48;
  localparam int FRAC_BITS   = 16;

  // solver datapath
  localparam int WIDE_W     = 128;
  localparam int LIMB_W     = 32;
  localparam int OP_W       = 2 * LIMB_W;
  localparam int PP_W       = 2 * LIMB_W;
  localparam int DIV_CNT_W  = $clog2(WIDE_W);
  localparam int PROD_IDX_W = 3;
  localparam int NUM_PRODS  = 6;

  // request queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // product codes
  localparam logic [PROD_IDX_W-1:0] P_NXX    = 3'd0;  // n * Sxx
  localparam logic [PROD_IDX_W-1:0] P_XX     = 3'd1;  // Sx * Sx
  localparam logic [PROD_IDX_W-1:0] P_SXX_SY = 3'd2;  // Sxx * Sy
  localparam logic [PROD_IDX_W-1:0] P_SX_SXY = 3'd3;  // Sx * Sxy
  localparam logic [PROD_IDX_W-1:0] P_N_SXY  = 3'd4;  // n * Sxy
  localparam logic [PROD_IDX_W-1:0] P_SX_SY  = 3'd5;  // Sx * Sy

  // limb-pair step of one 64x64 product
  localparam logic [1:0] STEP_FIRST = 2'b00;
  localparam logic [1:0] STEP_LAST  = 2'b11;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic            last;
    logic [Y_W-1:0]  sample_y;
    logic [X_W-1:0]  sample_x;
  } in_req_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] intercept;
    logic signed [COEF_W-1:0] slope;
    logic                     singular;
    logic [CNT_W-1:0]         sample_count;
  } out_res_t;

  // frozen sums of one finished set
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SX_W-1:0]  sum_x;
    logic [SXX_W-1:0] sum_xx;
    logic [SY_W-1:0]  sum_y;
    logic [SXY_W-1:0] sum_xy;
  } snap_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_DRAIN,
    BK_DET,
    BK_PREP,
    BK_NUM,
    BK_DIV,
    BK_SAT,
    BK_OUT
  } back_state_t;

endpackage

FILE: rtl/lslf_front.sv
// Front end: takes sample requests, forms x*x and x*y, keeps the running sums.
// Pushes a snapshot of the sums into the queue on a last sample. Uses lslf_pkg.
module lslf_front import lslf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  in_req_t in_req,
  input  q_stat_t q_stat,
  output logic    busy,
  output logic    push,
  output snap_t   push_snap
);

  logic             accept;
  logic             p_valid_r;
  logic             p_last_r;
  logic [X_W-1:0]   p_x_r;
  logic [Y_W-1:0]   p_y_r;
  logic [XX_W-1:0]  p_xx_r;
  logic [XY_W-1:0]  p_xy_r;

  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [SX_W-1:0]  sum_x_r,  sum_x_nxt;
  logic [SXX_W-1:0] sum_xx_r, sum_xx_nxt;
  logic [SY_W-1:0]  sum_y_r,  sum_y_nxt;
  logic [SXY_W-1:0] sum_xy_r, sum_xy_nxt;
  logic             add_ok;
  logic             last_pending;

  // a last sample in the product stage will take a queue slot next cycle
  assign last_pending = p_valid_r & p_last_r;
  assign busy   = ((QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(last_pending))
                  >= (QCNT_W+1)'(QDEPTH);
  assign accept = start & ~busy;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_last_r <= in_req.last;
      p_x_r    <= in_req.sample_x;
      p_y_r    <= in_req.sample_y;
      p_xx_r   <= XX_W'(in_req.sample_x) * XX_W'(in_req.sample_x);
      p_xy_r   <= XY_W'(in_req.sample_x) * XY_W'(in_req.sample_y);
    end
  end

  // accumulate stage; a full set ignores further samples
  assign add_ok = p_valid_r & (count_r < CNT_W'(MAX_SAMPLES));

  always_comb begin
    count_nxt  = count_r;
    sum_x_nxt  = sum_x_r;
    sum_xx_nxt = sum_xx_r;
    sum_y_nxt  = sum_y_r;
    sum_xy_nxt = sum_xy_r;
    if (add_ok) begin
      count_nxt  = count_r + CNT_W'(1);
      sum_x_nxt  = sum_x_r + SX_W'(p_x_r);
      sum_xx_nxt = sum_xx_r + SXX_W'(p_xx_r);
      sum_y_nxt  = sum_y_r + SY_W'(p_y_r);
      sum_xy_nxt = sum_xy_r + SXY_W'(p_xy_r);
    end
  end

  assign push             = last_pending;
  assign push_snap.count  = count_nxt;
  assign push_snap.sum_x  = sum_x_nxt;
  assign push_snap.sum_xx = sum_xx_nxt;
  assign push_snap.sum_y  = sum_y_nxt;
  assign push_snap.sum_xy = sum_xy_nxt;

  // sums clear once a set has been handed over
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      count_r  <= '0;
      sum_x_r  <= '0;
      sum_xx_r <= '0;
      sum_y_r  <= '0;
      sum_xy_r <= '0;
    end else begin
      count_r  <= count_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_xx_r <= sum_xx_nxt;
      sum_y_r  <= sum_y_nxt;
      sum_xy_r <= sum_xy_nxt;
    end
  end

endmodule

FILE: rtl/lslf_fifo.sv
// Two-entry queue of set snapshots between front end and solver.
// Uses lslf_pkg.
module lslf_fifo import lslf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  snap_t   wr_snap,
  input  logic    pop,
  output snap_t   rd_snap,
  output q_stat_t q_stat
);

  snap_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_snap;
    end
  end

  assign rd_snap      = mem[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.count = count_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: rtl/lslf_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses lslf_pkg.
module lslf_div import lslf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] num,
  input  logic [WIDE_W-1:0] den,
  output logic              done,
  output logic [WIDE_W-1:0] quo
);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WIDE_W-1:0]    num_r;
  logic [WIDE_W-1:0]    den_r;
  logic [WIDE_W-1:0]    rem_r;
  logic [WIDE_W-1:0]    quo_r;
  logic [WIDE_W:0]      trial;
  logic [WIDE_W:0]      diff;
  logic                 qbit;

  // shift in next numerator bit and try the subtract
  assign trial = {rem_r, num_r[WIDE_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = ~diff[WIDE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r & (cnt_r == DIV_CNT_W'(WIDE_W - 1));
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == DIV_CNT_W'(WIDE_W - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[WIDE_W-2:0], 1'b0};
      rem_r <= qbit ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
      quo_r <= {quo_r[WIDE_W-2:0], qbit};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/lslf_back.sv
// Solver: pulls a snapshot, forms six wide products on a shared 32x32
// multiplier, then the determinant and both coefficients. Uses lslf_pkg, lslf_div.
module lslf_back import lslf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_stat_t  q_stat,
  input  snap_t    rd_snap,
  output logic     pop,
  output logic     out_strobe,
  output out_res_t out_res
);

  back_state_t state_r, state_nxt;

  // control decoded from state
  logic mul_en;
  logic det_en;
  logic prep_en;
  logic div_start;
  logic sat_en;

  snap_t                 snap_r;
  logic [PROD_IDX_W-1:0] mul_k_r;
  logic [1:0]            mul_s_r;
  logic                  coef_sel_r;
  logic                  mul_last;

  logic [OP_W-1:0]       a_op;
  logic [OP_W-1:0]       b_op;
  logic [LIMB_W-1:0]     a_limb;
  logic [LIMB_W-1:0]     b_limb;
  logic [PP_W-1:0]       pp_calc;
  logic [PP_W-1:0]       pp_r;
  logic [PROD_IDX_W-1:0] pp_k_r;
  logic [1:0]            pp_sh_r;
  logic                  pp_first_r;
  logic                  pp_v_r;
  logic [WIDE_W-1:0]     pp_shifted;
  logic [WIDE_W-1:0]     prod_r [NUM_PRODS];

  logic                  singular_det;
  logic [WIDE_W-1:0]     det_r;
  logic                  neg_r;
  logic [WIDE_W-1:0]     mag_r;
  logic [WIDE_W-1:0]     plus;
  logic [WIDE_W-1:0]     minus;
  logic [WIDE_W-1:0]     div_num;
  logic                  div_done;
  logic [WIDE_W-1:0]     div_quo;
  logic                  q_big;
  logic [COEF_W-1:0]     q_lo;
  logic [COEF_W-1:0]     sat_val;
  out_res_t              res_r;

  function automatic logic [OP_W-1:0] op_a(input logic [PROD_IDX_W-1:0] k,
                                           input snap_t s);
    logic [OP_W-1:0] v;
    case (k)
      P_NXX:    v = OP_W'(s.count);
      P_N_SXY:  v = OP_W'(s.count);
      P_XX:     v = OP_W'(s.sum_x);
      P_SX_SXY: v = OP_W'(s.sum_x);
      P_SX_SY:  v = OP_W'(s.sum_x);
      P_SXX_SY: v = OP_W'(s.sum_xx);
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [OP_W-1:0] op_b(input logic [PROD_IDX_W-1:0] k,
                                           input snap_t s);
    logic [OP_W-1:0] v;
    case (k)
      P_NXX:    v = OP_W'(s.sum_xx);
      P_XX:     v = OP_W'(s.sum_x);
      P_SXX_SY: v = OP_W'(s.sum_y);
      P_SX_SXY: v = OP_W'(s.sum_xy);
      P_N_SXY:  v = OP_W'(s.sum_xy);
      P_SX_SY:  v = OP_W'(s.sum_y);
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign mul_last     = (mul_k_r == P_SX_SY) && (mul_s_r == STEP_LAST);
  assign singular_det = (prod_r[P_NXX] <= prod_r[P_XX]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = BK_MUL;
      BK_MUL:   if (mul_last) state_nxt = BK_DRAIN;
      BK_DRAIN: state_nxt = BK_DET;
      BK_DET:   state_nxt = singular_det ? BK_OUT : BK_PREP;
      BK_PREP:  state_nxt = BK_NUM;
      BK_NUM:   state_nxt = BK_DIV;
      BK_DIV:   if (div_done) state_nxt = BK_SAT;
      BK_SAT:   state_nxt = coef_sel_r ? BK_OUT : BK_PREP;
      BK_OUT:   state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop        = 1'b0;
    mul_en     = 1'b0;
    det_en     = 1'b0;
    prep_en    = 1'b0;
    div_start  = 1'b0;
    sat_en     = 1'b0;
    out_strobe = 1'b0;
    case (state_r)
      BK_IDLE: pop        = ~q_stat.empty;
      BK_MUL:  mul_en     = 1'b1;
      BK_DET:  det_en     = 1'b1;
      BK_PREP: prep_en    = 1'b1;
      BK_NUM:  div_start  = 1'b1;
      BK_SAT:  sat_en     = 1'b1;
      BK_OUT:  out_strobe = 1'b1;
      default: pop        = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pp_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pp_v_r  <= mul_en;
    end
  end

  // multiplier: one limb pair per cycle, registered before accumulation
  assign a_op    = op_a(mul_k_r, snap_r);
  assign b_op    = op_b(mul_k_r, snap_r);
  assign a_limb  = mul_s_r[1] ? a_op[OP_W-1:LIMB_W] : a_op[LIMB_W-1:0];
  assign b_limb  = mul_s_r[0] ? b_op[OP_W-1:LIMB_W] : b_op[LIMB_W-1:0];
  assign pp_calc = PP_W'(a_limb) * PP_W'(b_limb);

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = WIDE_W'(pp_r);
      2'd1:    pp_shifted = WIDE_W'(pp_r) << LIMB_W;
      default: pp_shifted = WIDE_W'(pp_r) << (2 * LIMB_W);
    endcase
  end

  // coefficient numerator operands
  always_comb begin
    if (coef_sel_r) begin
      plus  = prod_r[P_N_SXY];
      minus = prod_r[P_SX_SY];
    end else begin
      plus  = prod_r[P_SXX_SY];
      minus = prod_r[P_SX_SXY];
    end
  end

  // magnitude scaled to fixed point, plus half the divisor for rounding
  assign div_num = (mag_r << FRAC_BITS) + (det_r >> 1);

  lslf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // round-half-away result saturated to the coefficient range
  assign q_big = |div_quo[WIDE_W-1:COEF_W];
  assign q_lo  = div_quo[COEF_W-1:0];

  always_comb begin
    if (neg_r) begin
      sat_val = (q_big || q_lo > COEF_MIN) ? COEF_MIN : (COEF_W'(0) - q_lo);
    end else begin
      sat_val = (q_big || q_lo > COEF_MAX) ? COEF_MAX : q_lo;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      snap_r     <= rd_snap;
      mul_k_r    <= '0;
      mul_s_r    <= STEP_FIRST;
      coef_sel_r <= 1'b0;
    end
    if (mul_en) begin
      pp_r       <= pp_calc;
      pp_k_r     <= mul_k_r;
      pp_sh_r    <= {1'b0, mul_s_r[1]} + {1'b0, mul_s_r[0]};
      pp_first_r <= (mul_s_r == STEP_FIRST);
      mul_s_r    <= mul_s_r + 2'd1;
      if (mul_s_r == STEP_LAST) begin
        mul_k_r <= mul_k_r + PROD_IDX_W'(1);
      end
    end
    if (pp_v_r) begin
      prod_r[pp_k_r] <= pp_first_r ? pp_shifted : (prod_r[pp_k_r] + pp_shifted);
    end
    if (det_en) begin
      det_r              <= prod_r[P_NXX] - prod_r[P_XX];
      res_r.singular     <= singular_det;
      res_r.sample_count <= snap_r.count;
      res_r.intercept    <= '0;
      res_r.slope        <= '0;
    end
    if (prep_en) begin
      neg_r <= (plus < minus);
      mag_r <= (plus < minus) ? (minus - plus) : (plus - minus);
    end
    if (sat_en) begin
      if (coef_sel_r) begin
        res_r.slope <= $signed(sat_val);
      end else begin
        res_r.intercept <= $signed(sat_val);
      end
      coef_sel_r <= 1'b1;
    end
  end

  assign out_res = res_r;

endmodule

FILE: rtl/least_squares_line_fit.sv
// Top level of the least-squares line fit.
// Depends on lslf_pkg, lslf_front, lslf_fifo, lslf_back.
//
// Samples are taken one per cycle while busy is low; sums of n, x, x*x, y and
// x*y build up and the set closes on a request marked last. The closed set
// waits in a two-entry queue for the solver, which forms six wide products
// on one shared 32x32 multiplier, and then two coefficients with a
// one-bit-per-cycle 128-bit divider. Sampling of the next set runs on
// during a solve; busy rises only while the queue, together with a last
// request still in flight, is full. Each result is shown for one cycle
// with out_strobe and cannot be held off, so the receiver must take it
// then. A zero determinant returns singular with both coefficients zero.
module least_squares_line_fit import lslf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res
);

  logic    push;
  logic    pop;
  snap_t   push_snap;
  snap_t   rd_snap;
  q_stat_t q_stat;

  lslf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_snap (push_snap)
  );

  lslf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_snap (push_snap),
    .pop     (pop),
    .rd_snap (rd_snap),
    .q_stat  (q_stat)
  );

  lslf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .rd_snap    (rd_snap),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

FILE: rtl/lslf_checker.sv
// Port-level checks on the line fit results, bound to the top level.
// Uses lslf_pkg and least_squares_line_fit_defines.svh.
`include "least_squares_line_fit_defines.svh"

module lslf_checker import lslf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_strobe,
  input out_res_t out_res
);

  // the solver returns to idle after each result, so results never come back to back
  `LSLF_ASSERT_NXT(a_no_back_to_back, out_strobe, !out_strobe, "results back to back")

  // singular fit reports zero coefficients
  `LSLF_ASSERT_IMP(a_singular_zero, out_strobe && out_res.singular, out_res.intercept == '0 && out_res.slope == '0, "singular fit with nonzero coefficients")

  // a regular fit needs at least two samples
  `LSLF_ASSERT_IMP(a_fit_two_samples, out_strobe && !out_res.singular, out_res.sample_count >= CNT_W'(2), "fit from fewer than two samples")

  // every set has at least its last sample and never more than the limit
  `LSLF_ASSERT_IMP(a_count_range, out_strobe, out_res.sample_count != '0 && out_res.sample_count <= CNT_W'(MAX_SAMPLES), "sample count out of range")

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
